>>> src/gia_pkg.sv
// ----------------------------------------------------------------------------
// gia_pkg: shared types and constants for the guarded int32 ALU
// Function codes and the word that travels down the divider cell chain.
// ----------------------------------------------------------------------------
package gia_pkg;

  localparam int unsigned W = 32;

  typedef enum logic [3:0] {
    FN_ADD    = 4'd0,
    FN_SUB    = 4'd1,
    FN_MUL    = 4'd2,
    FN_DIV    = 4'd3,
    FN_MOD    = 4'd4,
    FN_OR     = 4'd5,
    FN_XOR    = 4'd6,
    FN_AND    = 4'd7,
    FN_LSH    = 4'd8,
    FN_RSH    = 4'd9,
    FN_URSH   = 4'd10,
    FN_BITNOT = 4'd11,
    FN_NEG    = 4'd12
  } func_t;

  // word handed from one cell to the next
  typedef struct packed {
    logic          vld;
    logic [W-1:0]  rem;     // partial remainder (magnitude)
    logic [W-1:0]  quo;     // dividend bits shifting out, quotient bits in
    logic [W-1:0]  dvs;     // divisor magnitude
    logic [W-1:0]  res;     // result when not a div/mod op
    logic          fail;
    logic          dbl;
    logic          is_div;
    logic          is_mod;
    logic          q_neg;
    logic          a_neg;
  } cell_t;

endpackage

>>> src/gia_cell.sv
// ----------------------------------------------------------------------------
// gia_cell: one restoring-division step
// Holds one word and passes it on every cycle the chain advances.
// ----------------------------------------------------------------------------
module gia_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  gia_pkg::cell_t d,
  output gia_pkg::cell_t q
);
  import gia_pkg::*;

  logic [W:0]   trial;
  logic [W-1:0] rsh;
  cell_t        nxt;

  always_comb begin
    nxt   = d;
    rsh   = {d.rem[W-2:0], d.quo[W-1]};
    trial = {d.rem[W-1], rsh} - {1'b0, d.dvs};
    if (d.is_div || d.is_mod) begin
      if (!trial[W]) begin
        nxt.rem = trial[W-1:0];
        nxt.quo = {d.quo[W-2:0], 1'b1};
      end else begin
        nxt.rem = rsh;
        nxt.quo = {d.quo[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (adv) begin
      q.vld <= d.vld;
    end
    if (adv) begin
      q.rem    <= nxt.rem;
      q.quo    <= nxt.quo;
      q.dvs    <= nxt.dvs;
      q.res    <= nxt.res;
      q.fail   <= nxt.fail;
      q.dbl    <= nxt.dbl;
      q.is_div <= nxt.is_div;
      q.is_mod <= nxt.is_mod;
      q.q_neg  <= nxt.q_neg;
      q.a_neg  <= nxt.a_neg;
    end
  end
endmodule

>>> src/gia_front.sv
// ----------------------------------------------------------------------------
// gia_front: operand guards and the non-division operations
// Registers a multiply, then builds the word that enters the cell chain.
// ----------------------------------------------------------------------------
module gia_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic [3:0]            func,
  input  logic signed [31:0]    lhs,
  input  logic signed [31:0]    rhs,
  input  logic                  lhs_is_int,
  input  logic                  rhs_is_int,
  input  logic                  allow_double,
  output gia_pkg::cell_t        q
);
  import gia_pkg::*;

  // stage 1 registers
  logic               s_vld;
  logic [3:0]         s_fn;
  logic [W-1:0]       s_a, s_b;
  logic               s_tag_ok;
  logic signed [63:0] s_prod;

  logic signed [32:0] sum, dif;
  logic [4:0]         sh;
  logic [W-1:0]       ur, ma, mb;
  logic               pre_fail, dv_bad;
  cell_t              nxt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (adv) begin
      s_vld <= in_vld;
    end
    if (adv) begin
      s_fn     <= func;
      s_a      <= lhs;
      s_b      <= rhs;
      s_tag_ok <= (func <= FN_URSH) ? (lhs_is_int && rhs_is_int)
                : (func <= FN_NEG)  ? lhs_is_int : 1'b0;
      s_prod   <= 64'(lhs) * 64'(rhs);
    end
  end

  always_comb begin
    sum = {s_a[W-1], s_a} + {s_b[W-1], s_b};
    dif = {s_a[W-1], s_a} - {s_b[W-1], s_b};
    sh  = s_b[4:0];
    ur  = s_a >> sh;
    ma  = s_a[W-1] ? (~s_a + 32'd1) : s_a;
    mb  = s_b[W-1] ? (~s_b + 32'd1) : s_b;
    dv_bad = (s_a == 32'h8000_0000 && s_b == 32'hFFFF_FFFF) || s_b == '0
             || (s_a == '0 && s_b[W-1]);
    pre_fail = !s_tag_ok;
    nxt = '0;
    nxt.vld   = s_vld;
    nxt.dvs   = mb;
    nxt.quo   = ma;
    nxt.q_neg = s_a[W-1] ^ s_b[W-1];
    nxt.a_neg = s_a[W-1];
    if (!pre_fail) begin
      unique case (s_fn)
        FN_ADD: begin
          nxt.res  = sum[W-1:0];
          nxt.fail = sum[32] != sum[31];
        end
        FN_SUB: begin
          nxt.res  = dif[W-1:0];
          nxt.fail = dif[32] != dif[31];
        end
        FN_MUL: begin
          nxt.res  = s_prod[W-1:0];
          nxt.fail = (s_prod[63:31] != {33{s_prod[31]}})
                     || (s_prod == '0 && (s_a[W-1] ^ s_b[W-1]));
        end
        FN_DIV: begin
          nxt.fail   = dv_bad;
          nxt.is_div = 1'b1;
        end
        FN_MOD: begin
          nxt.fail   = dv_bad;
          nxt.is_mod = 1'b1;
        end
        FN_OR:     nxt.res = s_a | s_b;
        FN_XOR:    nxt.res = s_a ^ s_b;
        FN_AND:    nxt.res = s_a & s_b;
        FN_LSH:    nxt.res = s_a << sh;
        FN_RSH:    nxt.res = $unsigned($signed(s_a) >>> sh);
        FN_URSH: begin
          nxt.res  = ur;
          nxt.dbl  = ur[W-1] && allow_double;
          nxt.fail = ur[W-1] && !allow_double;
        end
        FN_BITNOT: nxt.res = ~s_a;
        FN_NEG: begin
          nxt.res  = ~s_a + 32'd1;
          nxt.fail = s_a[W-2:0] == '0;
        end
        default:   nxt.fail = 1'b1;
      endcase
    end else begin
      nxt.fail = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (adv) begin
      q.vld <= nxt.vld;
    end
    if (adv) begin
      q.rem    <= '0;
      q.quo    <= nxt.quo;
      q.dvs    <= nxt.dvs;
      q.res    <= nxt.res;
      q.fail   <= nxt.fail;
      q.dbl    <= nxt.dbl;
      q.is_div <= nxt.is_div;
      q.is_mod <= nxt.is_mod;
      q.q_neg  <= nxt.q_neg;
      q.a_neg  <= nxt.a_neg;
    end
  end
endmodule

>>> src/guarded_int32_alu_core.sv
// ----------------------------------------------------------------------------
// guarded_int32_alu_core: 32-bit integer ALU with fast-path guards
//
//   channel   valid      stall       payload
//   in        in_valid   in_stall    func lhs rhs lhs_is_int rhs_is_int
//   out       out_valid  out_stall   result fail as_double
//   cfg       cfg_we     -           cfg_data (allow_double)
//
// One word per cycle unless out_stall holds the chain: 2 front stages
// (multiply, guards), then a chain of 32 division cells, then the output
// register. All stages move together; out_stall holds the whole chain, and
// in_stall follows out_stall only while the output register is full.
// Synchronous reset empties the pipeline and clears allow_double.
// ----------------------------------------------------------------------------
module guarded_int32_alu_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         func,
  input  logic signed [31:0] lhs,
  input  logic signed [31:0] rhs,
  input  logic               lhs_is_int,
  input  logic               rhs_is_int,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        result,
  output logic               fail,
  output logic               as_double,
  input  logic               cfg_we,
  input  logic               cfg_data
);
  import gia_pkg::*;

  logic   allow_double;
  logic   adv;
  cell_t  chain [0:W];
  logic [W-1:0] quo, rem;
  logic   div_fail;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_double <= 1'b0;
    end else if (cfg_we) begin
      allow_double <= cfg_data;
    end
  end

  gia_front u_front (
    .clk, .rst, .adv,
    .in_vld (in_valid && !in_stall),
    .func, .lhs, .rhs, .lhs_is_int, .rhs_is_int,
    .allow_double,
    .q      (chain[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_cell
    gia_cell u_cell (.clk, .rst, .adv, .d(chain[i]), .q(chain[i+1]));
  end

  always_comb begin
    quo = chain[W].q_neg ? (~chain[W].quo + 32'd1) : chain[W].quo;
    rem = chain[W].a_neg ? (~chain[W].rem + 32'd1) : chain[W].rem;
    div_fail = 1'b0;
    if (chain[W].is_div) begin
      div_fail = chain[W].rem != '0;
    end else if (chain[W].is_mod) begin
      div_fail = chain[W].rem == '0 && chain[W].a_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain[W].vld;
    end
    if (adv) begin
      fail      <= chain[W].fail || div_fail;
      as_double <= chain[W].dbl && !(chain[W].fail || div_fail);
      if (chain[W].fail || div_fail) begin
        result <= '0;
      end else if (chain[W].is_div) begin
        result <= quo;
      end else if (chain[W].is_mod) begin
        result <= rem;
      end else begin
        result <= chain[W].res;
      end
    end
  end
endmodule
